/* src/float32_multiplier_defines.svh */
// ----------------------------------------------------------------------------
// float32_multiplier_defines
// Assertion macros used by float32_multiplier.
// ----------------------------------------------------------------------------
`ifndef FLOAT32_MULTIPLIER_DEFINES_SVH
`define FLOAT32_MULTIPLIER_DEFINES_SVH
`ifndef ASSERT_OFF
`define FM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FM_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FM_ASSERT(label, clk, rst_n, prop, msg)
`define FM_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* src/fmul_pkg.sv */
// ----------------------------------------------------------------------------
// fmul_pkg
// Constants and types for the single-precision multiplier.
// ----------------------------------------------------------------------------
package fmul_pkg;
    localparam int unsigned FRAC_W = 23;
    localparam int unsigned EXP_W  = 8;
    localparam int unsigned SIG_W  = 24;
    localparam int unsigned PROD_W = 48;
    localparam int unsigned EXP_BIAS = 127;
    localparam int unsigned EXP_MAX  = 254;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic                    sign;
        logic                    zero;
        logic signed [EXP_W+1:0] exp;
    } t_side;
endpackage

/* src/fmul_mult.sv */
// ----------------------------------------------------------------------------
// fmul_mult
// Two-stage significand multiplier: partial products, then their sum.
// ----------------------------------------------------------------------------
module fmul_mult (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [fmul_pkg::SIG_W-1:0]        i_sig_a,
    input  logic [fmul_pkg::SIG_W-1:0]        i_sig_b,
    output logic [fmul_pkg::PROD_W-1:0]       o_prod
);
    logic [35:0] r_lo;
    logic [35:0] r_hi;
    logic [fmul_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= {12'd0, i_sig_a} * {24'd0, i_sig_b[11:0]};
            r_hi <= {12'd0, i_sig_a} * {24'd0, i_sig_b[23:12]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= {12'd0, r_lo} + {r_hi, 12'd0};
        end
    end

    assign o_prod = r_prod;
endmodule

/* src/fmul_round.sv */
// ----------------------------------------------------------------------------
// fmul_round
// Normalize, round to nearest even, range check and pack.
// ----------------------------------------------------------------------------
module fmul_round (
    input  logic [fmul_pkg::PROD_W-1:0] i_prod,
    input  fmul_pkg::t_side             i_side,
    output logic [31:0]                 o_product,
    output fmul_pkg::t_status           o_status
);
    logic        top;
    logic [23:0] kept;
    logic        guard;
    logic        sticky;
    logic        round_up;
    logic [23:0] rounded;
    logic signed [fmul_pkg::EXP_W+1:0] e;

    always_comb begin
        top = i_prod[47];
        if (top) begin
            kept   = {1'b0, i_prod[46:24]};
            guard  = i_prod[23];
            sticky = |i_prod[22:0];
        end else begin
            kept   = {1'b0, i_prod[45:23]};
            guard  = i_prod[22];
            sticky = |i_prod[21:0];
        end
        round_up = guard & (sticky | kept[0]);
        rounded  = kept + 24'(round_up);
        e = i_side.exp + 10'(top) + 10'(rounded[23]);
        if (i_side.zero) begin
            o_product = {i_side.sign, 31'd0};
            o_status  = fmul_pkg::ST_OK;
        end else if (e > 10'sd254) begin
            o_product = 32'd0;
            o_status  = fmul_pkg::ST_OVERFLOW;
        end else if (e < 10'sd0) begin
            o_product = 32'd0;
            o_status  = fmul_pkg::ST_UNDERFLOW;
        end else begin
            o_product = {i_side.sign, e[7:0], rounded[22:0]};
            o_status  = fmul_pkg::ST_OK;
        end
    end
endmodule

/* src/float32_multiplier.sv */
// ----------------------------------------------------------------------------
// float32_multiplier
// Stages: operand registers, partial products, product sum, rounded output register.
// Throughput: one word per cycle when not stalled; the four pipeline stages advance together.
// Reset: synchronous active-low i_rst_n clears all valid bits.
// ----------------------------------------------------------------------------
`include "float32_multiplier_defines.svh"
module float32_multiplier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_product,
    output logic [1:0]  o_status
);
    logic [3:0] r_vld;
    logic       adv;
    fmul_pkg::t_side r_s0, r_s1, r_s2, n_s0;
    logic [fmul_pkg::SIG_W-1:0] r_sa, r_sb;
    logic [fmul_pkg::PROD_W-1:0] prod;
    logic [31:0] n_product, r_product;
    fmul_pkg::t_status n_status, r_status;

    assign adv     = !(r_vld[3] && i_stall);
    assign o_stall = !adv;

    always_comb begin
        n_s0.sign = i_operand_a[31] ^ i_operand_b[31];
        n_s0.zero = (i_operand_a[30:0] == 31'd0) || (i_operand_b[30:0] == 31'd0);
        n_s0.exp  = $signed({2'b00, i_operand_a[30:23]}) + $signed({2'b00, i_operand_b[30:23]})
                    - 10'sd127;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0 <= n_s0;
            r_sa <= {1'b1, i_operand_a[22:0]};
            r_sb <= {1'b1, i_operand_b[22:0]};
            r_s1 <= r_s0;
            r_s2 <= r_s1;
            r_product <= n_product;
            r_status  <= n_status;
        end
    end

    fmul_mult u_mult (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_sig_a (r_sa),
        .i_sig_b (r_sb),
        .o_prod  (prod)
    );

    fmul_round u_round (
        .i_prod    (prod),
        .i_side    (r_s2),
        .o_product (n_product),
        .o_status  (n_status)
    );

    assign o_valid   = r_vld[3];
    assign o_product = r_product;
    assign o_status  = r_status;

    `FM_ASSERT(a_stall_only_full, i_clk, i_rst_n, o_stall |-> o_valid, "stall without output")
    `FM_ASSERT(a_err_zero, i_clk, i_rst_n, (o_valid && o_status != fmul_pkg::ST_OK) |-> (o_product == 32'd0), "error product nonzero")
    `FM_ASSERT(a_status_code, i_clk, i_rst_n, o_valid |-> (o_status != 2'd3), "bad status")
    `FM_ASSERT_NR(a_reset_clear, i_clk, !i_rst_n |=> !o_valid, "valid after reset")
endmodule

/* bench/tb_float32_multiplier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_float32_multiplier
// Drives operand pairs through the single-precision multiplier under several
// idle and stall patterns, predicts each product and status, and compares
// every output word in order against the predicted queue.
// ----------------------------------------------------------------------------
module tb_float32_multiplier;

    typedef struct packed {
        logic [31:0]       product;
        fmul_pkg::t_status status;
    } t_fmul_word;

    // Predict one product word.
    function automatic t_fmul_word fmul_predict(logic [31:0] a, logic [31:0] b);
        t_fmul_word   w;
        logic         sign;
        logic [47:0]  p;
        logic [47:0]  rem;
        logic [47:0]  half;
        logic [23:0]  kept;
        logic         top;
        int           sh;
        int           e;
        logic         rnd;
        sign = a[31] ^ b[31];
        w.product = '0;
        w.status = fmul_pkg::ST_OK;
        if ((a[30:23] == 0 && a[22:0] == 0) || (b[30:23] == 0 && b[22:0] == 0)) begin
            w.product = {sign, 31'd0};
            return w;
        end
        p = {24'd0, 1'b1, a[22:0]} * {24'd0, 1'b1, b[22:0]};
        top = p[47];
        sh = top ? 24 : 23;
        rem = p & ((48'd1 << sh) - 48'd1);
        half = 48'd1 << (sh - 1);
        kept = {1'b0, 23'((p >> sh))};
        rnd = (rem > half) || (rem == half && kept[0]);
        kept = kept + 24'(rnd);
        e = int'(a[30:23]) + int'(b[30:23]) - int'(fmul_pkg::EXP_BIAS) + int'(top)
            + int'(kept[23]);
        if (e > int'(fmul_pkg::EXP_MAX)) begin
            w.status = fmul_pkg::ST_OVERFLOW;
        end else if (e < 0) begin
            w.status = fmul_pkg::ST_UNDERFLOW;
        end else begin
            w.product = {sign, e[7:0], kept[22:0]};
        end
        return w;
    endfunction

    int mismatches = 0;

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    class fmul_scoreboard;
        t_fmul_word pending[$];

        function void note_operands(logic [31:0] a, logic [31:0] b);
            pending.push_back(fmul_predict(a, b));
        endfunction

        task check_word(logic [31:0] product, logic [1:0] status);
            t_fmul_word w;
            if (pending.size() == 0) begin
                report($sformatf("unexpected word %h/%0d", product, status));
                return;
            end
            w = pending.pop_front();
            if (product !== w.product)
                report($sformatf("product %h, want %h", product, w.product));
            if (status !== w.status)
                report($sformatf("status %0d, want %0d", status, w.status));
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [31:0] i_operand_a = 0;
    logic [31:0] i_operand_b = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [31:0] o_product;
    logic [1:0]  o_status;

    float32_multiplier uut (.*);

    always #6 i_clk = ~i_clk;

    fmul_scoreboard sb = new();
    int  send_idle = 0;
    int  recv_stall = 0;
    bit  hold_off = 0;
    longint cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_word(o_product, o_status);
        if (i_rst_n && i_valid && !o_stall)
            sb.note_operands(i_operand_a, i_operand_b);
    end

    always @(posedge i_clk) begin
        if (hold_off)
            i_stall <= 1'b1;
        else
            i_stall <= ($urandom_range(99) < recv_stall);
    end

    task automatic send_word(logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_operand();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(9))
            0: w[30:0] = 31'd0;
            1: w[30:23] = 8'(127 + $urandom_range(0, 10) - 5);
            2: w[30:23] = 8'($urandom_range(60, 70));
            3: w[30:23] = 8'($urandom_range(185, 200));
            4: w[22:0] = 23'd0;
            default: ;
        endcase
        return w;
    endfunction

    task automatic random_phase(int n, int idle, int stall);
        send_idle = idle;
        recv_stall = stall;
        repeat (n) send_word(rand_operand(), rand_operand());
        send_idle = 0;
        recv_stall = 0;
        drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_word(32'h0000_0000, 32'h7F80_0000);
        send_word(32'h8000_0000, 32'h3F80_0000);
        send_word(32'h7FC0_0000, 32'h8000_0000);
        send_word(32'h3F80_0000, 32'h3F80_0000);
        send_word(32'hBFC0_0000, 32'h4000_0000);
        send_word(32'h7F7F_FFFF, 32'h7F7F_FFFF);
        send_word(32'h0080_0000, 32'h0080_0000);
        send_word(32'h0000_0001, 32'h7F00_0000);
        send_word(32'h3FFF_FFFF, 32'h3FFF_FFFF);
        send_word(32'h3F80_0001, 32'h3F80_0001);
        send_word(32'h3FC0_0001, 32'h3FC0_0001);
        send_word(32'h3F80_0001, 32'h3FFF_FFFF);
        send_word(32'h3F7F_FFFF, 32'h0080_0000);
        send_word(32'h2000_0000, 32'h1F00_0000);
        send_word(32'h7F80_0000, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF, 32'h0000_0001);
        send_word(32'h4000_0000, 32'h7F00_0000);
        send_word(32'h3F00_0000, 32'h0080_0000);
        drain();
        random_phase(250, 0, 0);
        random_phase(200, 80, 0);
        random_phase(200, 0, 80);
        random_phase(200, 33, 33);
        fork
            begin
                hold_off = 1;
                repeat (60) @(posedge i_clk);
                hold_off = 0;
            end
            begin
                repeat (40) send_word(rand_operand(), rand_operand());
                i_valid <= 1'b0;
            end
        join
        drain();
        random_phase(150, 10, 10);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+src
src/fmul_pkg.sv
src/fmul_mult.sv
src/fmul_round.sv
src/float32_multiplier.sv
bench/tb_float32_multiplier.sv
